/* design/swm_pkg.sv */
package swm_pkg;

  // Number of samples the ring holds.
  localparam int CAPACITY = 256;

  localparam int SAMPLE_W = 16;
  localparam int WL_W     = 9;
  localparam int USED_W   = 9;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = SAMPLE_W + $clog2(CAPACITY);
  localparam int CMP_W    = (CNT_W > WL_W) ? CNT_W : WL_W;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [WL_W-1:0]            wlen_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [SUM_W-1:0]           mag_t;
  typedef logic [USED_W-1:0]          used_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_DONE
  } state_t;

  // Request from the controller to the divider.
  typedef struct packed {
    logic start;
    logic neg;
    mag_t mag;
    cnt_t divisor;
  } div_req_t;

  // Window length in effect once the ring is full enough: zero and lengths
  // beyond the ring both mean the whole ring.
  function automatic cnt_t effective_window(wlen_t wl);
    logic [CMP_W-1:0] wl_x;
    wl_x = CMP_W'(wl);
    if (wl_x == '0 || wl_x > CMP_W'(CAPACITY)) begin
      return CNT_W'(CAPACITY);
    end
    return CNT_W'(wl_x);
  endfunction

  // Sample count as reported on the output, modulo its field width.
  function automatic used_t to_used(cnt_t w);
    logic [31:0] t;
    t = 32'(w);
    return t[USED_W-1:0];
  endfunction

endpackage

/* design/sliding_window_mean.sv */
// Moving average over the newest samples of a signed Q8.8 stream. Each
// input beat appends one sample to a ring of CAPACITY entries in a
// single-port RAM and yields one output beat: the mean of the newest W
// samples, truncated toward zero, and W itself. W is the window register,
// or the number of samples stored when the register is zero or larger than
// that number. A running sum is updated with the new sample and the one that
// leaves the window, so each beat costs one RAM read and one RAM write; the
// bit-serial divider then bounds the rate (accept, ring update, 24 divide
// steps, a state to see the divider finish, output load held by a full output).
// The next input beat is taken while the previous result still waits on the
// output. Writing the window register restarts the series; write it only
// while the block is idle.
module sliding_window_mean (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,   // window_length
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // [15:0] sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata      // [15:0] average, [24:16] samples_used
);

  swm_pkg::state_t   state_r, state_nxt;
  swm_pkg::wlen_t    wl_r;
  swm_pkg::addr_t    wp_r, wp_nxt;
  swm_pkg::cnt_t     fill_r, fill_nxt;
  swm_pkg::sum_t     sum_r, sum_nxt;
  swm_pkg::sample_t  x_r;
  swm_pkg::cnt_t     w_r, w_nxt;
  logic              out_valid_r;
  swm_pkg::sample_t  avg_r;
  swm_pkg::used_t    used_r;

  swm_pkg::cnt_t     eff;
  logic              ram_we;
  swm_pkg::addr_t    ram_addr;
  swm_pkg::sample_t  ram_rdata;
  logic [swm_pkg::SAMPLE_W-1:0] ram_rraw;
  swm_pkg::addr_t    old_addr;
  logic [swm_pkg::CNT_W:0] wp_ext;
  swm_pkg::sample_t  leave;
  swm_pkg::div_req_t div_req;
  logic              div_busy;
  swm_pkg::sample_t  div_q;
  logic              load_out;

  assign eff = swm_pkg::effective_window(wl_r);

  // Slot of the sample that drops out of the window; read before the new
  // sample is written, since with a full-ring window it is the same slot.
  always_comb begin
    wp_ext = (swm_pkg::CNT_W + 1)'(wp_r);
    if (wp_ext >= {1'b0, eff}) begin
      old_addr = swm_pkg::ADDR_W'(wp_ext - {1'b0, eff});
    end else begin
      old_addr = swm_pkg::ADDR_W'(wp_ext + (swm_pkg::CNT_W + 1)'(swm_pkg::CAPACITY)
                                  - {1'b0, eff});
    end
  end

  assign ram_rdata = swm_pkg::sample_t'(ram_rraw);
  assign leave     = (fill_r >= eff) ? ram_rdata : '0;

  always_comb begin
    state_nxt = state_r;
    wp_nxt    = wp_r;
    fill_nxt  = fill_r;
    sum_nxt   = sum_r;
    w_nxt     = w_r;
    ram_we    = 1'b0;
    ram_addr  = old_addr;
    load_out  = 1'b0;
    in_tready = 1'b0;
    div_req   = '0;
    unique case (state_r)
      swm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = swm_pkg::ST_UPDATE;
        end
      end
      swm_pkg::ST_UPDATE: begin
        ram_we   = 1'b1;
        ram_addr = wp_r;
        sum_nxt  = sum_r + swm_pkg::SUM_W'(x_r) - swm_pkg::SUM_W'(leave);
        if (wp_r == swm_pkg::ADDR_W'(swm_pkg::CAPACITY - 1)) begin
          wp_nxt = '0;
        end else begin
          wp_nxt = wp_r + 1'b1;
        end
        if (fill_r != swm_pkg::CNT_W'(swm_pkg::CAPACITY)) begin
          fill_nxt = fill_r + 1'b1;
        end
        w_nxt = (fill_nxt < eff) ? fill_nxt : eff;
        div_req.start   = 1'b1;
        div_req.neg     = sum_nxt[swm_pkg::SUM_W-1];
        div_req.mag     = sum_nxt[swm_pkg::SUM_W-1] ? swm_pkg::mag_t'(-sum_nxt)
                                                    : swm_pkg::mag_t'(sum_nxt);
        div_req.divisor = w_nxt;
        state_nxt = swm_pkg::ST_DIV;
      end
      swm_pkg::ST_DIV: begin
        if (!div_busy) begin
          state_nxt = swm_pkg::ST_DONE;
        end
      end
      swm_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = swm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = swm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swm_pkg::ST_IDLE;
      wl_r        <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        wl_r   <= cfg_wr_data;
        wp_r   <= '0;
        fill_r <= '0;
        sum_r  <= '0;
      end else begin
        wp_r   <= wp_nxt;
        fill_r <= fill_nxt;
        sum_r  <= sum_nxt;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_tvalid && in_tready) begin
      x_r <= swm_pkg::sample_t'(in_tdata);
    end
    w_r <= w_nxt;
    if (load_out) begin
      avg_r  <= div_q;
      used_r <= swm_pkg::to_used(w_r);
    end
  end

  swm_ram #(
    .WIDTH(swm_pkg::SAMPLE_W),
    .DEPTH(swm_pkg::CAPACITY)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (x_r),
    .rdata (ram_rraw)
  );

  swm_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, used_r, avg_r};

endmodule

/* design/swm_ram.sv */
module swm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                          wdata,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* design/swm_divider.sv */
module swm_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  swm_pkg::div_req_t   req,
  output logic                busy,
  output swm_pkg::sample_t    quotient
);

  localparam int STEP_W = $clog2(swm_pkg::SUM_W + 1);

  logic                   busy_r, busy_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  swm_pkg::mag_t          q_r, q_nxt;
  swm_pkg::cnt_t          rem_r, rem_nxt;
  swm_pkg::cnt_t          div_r, div_nxt;
  logic                   neg_r, neg_nxt;
  logic [swm_pkg::CNT_W:0] trial;
  swm_pkg::mag_t          signed_q;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    trial    = {rem_r, q_r[swm_pkg::SUM_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      q_nxt    = req.mag;
      rem_nxt  = '0;
      div_nxt  = req.divisor;
      neg_nxt  = req.neg;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = swm_pkg::CNT_W'(trial - {1'b0, div_r});
        q_nxt   = {q_r[swm_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[swm_pkg::CNT_W-1:0];
        q_nxt   = {q_r[swm_pkg::SUM_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(swm_pkg::SUM_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
  end

  assign signed_q = neg_r ? (~q_r + 1'b1) : q_r;
  assign quotient = signed_q[swm_pkg::SAMPLE_W-1:0];
  assign busy     = busy_r;

endmodule

/* tb/sv/tb_sliding_window_mean.sv */
`timescale 1ns / 100ps

module tb_sliding_window_mean;

  typedef struct packed {
    swm_pkg::sample_t avg;
    swm_pkg::used_t   used;
  } mean_res_t;

  typedef struct packed {
    logic             typed;
    swm_pkg::sample_t sample;
    mean_res_t        res;
  } stim_row_t;

  localparam int N_DIRECTED = 22;
  localparam int N_PHASES   = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 30;
  localparam int TAIL_CYCLES = 40;

  // Rows with typed set carry an expectation written out by hand; the others
  // are checked against the predictor. The series starts with window zero.
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{1'b1, 16'sh7FFF, '{16'sh7FFF, 9'd1}},
    '{1'b1, 16'sh8000, '{16'sh0000, 9'd2}},
    '{1'b0, 16'sh8000, '{16'sh0000, 9'd0}},
    '{1'b0, 16'sh0001, '{16'sh0000, 9'd0}},
    '{1'b0, 16'shFFFF, '{16'sh0000, 9'd0}},
    '{1'b0, 16'sh0000, '{16'sh0000, 9'd0}},
    '{1'b0, 16'sh7FFF, '{16'sh0000, 9'd0}},
    '{1'b0, 16'sh7FFF, '{16'sh0000, 9'd0}},
    '{1'b0, 16'sh8000, '{16'sh0000, 9'd0}},
    '{1'b0, 16'sh5555, '{16'sh0000, 9'd0}},
    '{1'b0, 16'shAAAA, '{16'sh0000, 9'd0}},
    '{1'b0, 16'sh0100, '{16'sh0000, 9'd0}},
    '{1'b0, 16'shFF00, '{16'sh0000, 9'd0}},
    '{1'b0, 16'sh00FF, '{16'sh0000, 9'd0}},
    '{1'b0, 16'shFF01, '{16'sh0000, 9'd0}},
    '{1'b0, 16'sh1234, '{16'sh0000, 9'd0}},
    '{1'b0, 16'shEDCC, '{16'sh0000, 9'd0}},
    '{1'b0, 16'sh4000, '{16'sh0000, 9'd0}},
    '{1'b0, 16'shC000, '{16'sh0000, 9'd0}},
    '{1'b0, 16'sh0080, '{16'sh0000, 9'd0}},
    '{1'b0, 16'sh7FFE, '{16'sh0000, 9'd0}},
    '{1'b0, 16'sh8001, '{16'sh0000, 9'd0}}
  };

  localparam int PHASE_ITEMS [N_PHASES] = '{20, 40, 280, 30, 20, 20, 25, 15};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [8:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;      // [15:0] sample
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;     // [15:0] average, [24:16] samples_used

  // Predictor state: a private copy of the ring and the window register.
  swm_pkg::sample_t ring_copy [swm_pkg::CAPACITY];
  int unsigned      next_slot;
  int unsigned      stored;
  swm_pkg::wlen_t   window_reg;

  mean_res_t   expected_means [$];
  int          mismatch_count = 0;

  logic        sender_steady;
  logic        receiver_steady;
  logic        hold_req;

  sliding_window_mean u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("sliding_window_mean test failed");
    $finish;
  end

  // Appends one sample and returns the truncated mean of the newest window.
  function automatic mean_res_t predict_mean(input swm_pkg::sample_t s);
    mean_res_t   r;
    int unsigned w;
    int unsigned slot;
    longint      acc;
    longint      quot;
    ring_copy[swm_pkg::ADDR_W'(next_slot)] = s;
    next_slot = (next_slot + 1) % swm_pkg::CAPACITY;
    if (stored < swm_pkg::CAPACITY) begin
      stored++;
    end
    w = 32'(window_reg);
    if (w == 0 || w > stored) begin
      w = stored;
    end
    acc = 0;
    for (int k = 0; k < w; k++) begin
      slot = (next_slot + swm_pkg::CAPACITY - 1 - k) % swm_pkg::CAPACITY;
      acc += ring_copy[swm_pkg::ADDR_W'(slot)];
    end
    quot = acc / longint'(w);
    r.avg  = quot[15:0];
    r.used = w[8:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(30, 90);
  endfunction

  function automatic swm_pkg::sample_t rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0: return 16'sh7FFF;
        1: return 16'sh8000;
        2: return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    end else if (r < 30) begin
      return swm_pkg::sample_t'($urandom_range(0, 511) - 256);
    end
    return swm_pkg::sample_t'($urandom);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high.
  task automatic offer_sample(input swm_pkg::sample_t s, input logic typed,
                              input mean_res_t typed_res);
    mean_res_t predicted;
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do begin
      @(posedge clk);
    end while (!in_tready);
    predicted = predict_mean(s);
    expected_means.insert(expected_means.size(), typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int g;
    g = pick_gap();
    if (!sender_steady && g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Waits until the block has drained, then writes the window register.
  task automatic write_window(input swm_pkg::wlen_t value);
    in_tvalid <= 1'b0;
    while (expected_means.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    window_reg = value;
    next_slot  = 0;
    stored     = 0;
  endtask

  always @(posedge clk) begin : check_means
    mean_res_t want;
    mean_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.avg  = out_tdata[15:0];
      got.used = out_tdata[24:16];
      if (expected_means.size() == 0) begin
        $display("%0t ns: unexpected result, average %0d samples_used %0d",
                 $time, got.avg, got.used);
        mismatch_count++;
      end else begin
        want = expected_means.pop_front();
        if (got.avg !== want.avg) begin
          $display("%0t ns: average expected %0d got %0d", $time, want.avg, got.avg);
          mismatch_count++;
        end
        if (got.used !== want.used) begin
          $display("%0t ns: samples_used expected %0d got %0d",
                   $time, want.used, got.used);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver: random stalls, steady stretches, and one long hold-off on request.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!receiver_steady && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_window [N_PHASES];
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    hold_req        = 1'b0;
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
    window_reg      = '0;
    next_slot       = 0;
    stored          = 0;
    phase_window = '{1, 3, 0, 17, 511, 257, 256, $urandom_range(2, 255)};

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      offer_sample(DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
      sender_gap();
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_window(swm_pkg::wlen_t'(phase_window[p]));
      sender_steady   = ($urandom_range(0, 3) == 0);
      receiver_steady = ($urandom_range(0, 3) == 0);
      // The window-three phase keeps the output blocked for a long stretch
      // while the sender pushes without gaps, so the input side stalls.
      if (p == 1) begin
        sender_steady = 1'b1;
        hold_req      = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        offer_sample(rand_sample(), 1'b0, '0);
        sender_gap();
      end
    end

    in_tvalid <= 1'b0;
    while (expected_means.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_means.size() == 0) begin
      $display("sliding_window_mean test passed");
    end else begin
      $display("sliding_window_mean test failed");
    end
    $finish;
  end

endmodule

/* sliding_window_mean.f */
design/swm_pkg.sv
design/swm_ram.sv
design/swm_divider.sv
design/sliding_window_mean.sv
tb/sv/tb_sliding_window_mean.sv
